// ===== sv/ppp_pkg.sv =====
`timescale 1ns / 1ps

package ppp_pkg;

   // Parser phases, one-hot.
   typedef enum logic [13:0] {
      PH_START      = 14'b00_0000_0000_0001,
      PH_NAME       = 14'b00_0000_0000_0010,
      PH_UIDX_FIRST = 14'b00_0000_0000_0100,
      PH_UIDX_DIG   = 14'b00_0000_0000_1000,
      PH_AFTER      = 14'b00_0000_0001_0000,
      PH_TYPE_FIRST = 14'b00_0000_0010_0000,
      PH_TYPE       = 14'b00_0000_0100_0000,
      PH_PROP_FIRST = 14'b00_0000_1000_0000,
      PH_PROP       = 14'b00_0001_0000_0000,
      PH_CLOSED     = 14'b00_0010_0000_0000,
      PH_TIDX_FIRST = 14'b00_0100_0000_0000,
      PH_TIDX_DIG   = 14'b00_1000_0000_0000,
      PH_NEED_CLOSE = 14'b01_0000_0000_0000,
      PH_ERROR      = 14'b10_0000_0000_0000
   } phase_type;

   // Role tags of a byte.
   localparam logic [2:0] ROLE_NONE    = 3'd0;
   localparam logic [2:0] ROLE_TYPE    = 3'd1;
   localparam logic [2:0] ROLE_PROP    = 3'd2;
   localparam logic [2:0] ROLE_DIGIT   = 3'd3;
   localparam logic [2:0] ROLE_BRACKET = 3'd4;
   localparam logic [2:0] ROLE_SEP     = 3'd5;

   // Path status codes.
   localparam logic [1:0] ST_PARSING   = 2'd0;
   localparam logic [1:0] ST_COMPLETED = 2'd1;
   localparam logic [1:0] ST_ERROR     = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   // Characters of the path grammar.
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CH_LBRACKET   = 8'h5B;
   localparam logic [7:0] CH_RBRACKET   = 8'h5D;
   localparam logic [7:0] CH_LPAREN     = 8'h28;
   localparam logic [7:0] CH_RPAREN     = 8'h29;
   localparam logic [7:0] CH_DOT        = 8'h2E;
   localparam logic [7:0] CH_ZERO       = 8'h30;
   localparam logic [7:0] CH_NINE       = 8'h39;

   // Decoded action for one byte, passed from the step decoder to the top level.
   typedef struct packed {
      phase_type  phase;
      logic [2:0] role;
      logic       done;
      logic       set_paren;
      logic       start_idx;
      logic       add_dig;
      logic       next_comp;
   } step_type;

endpackage

// ===== sv/ppp_step.sv =====
`timescale 1ns / 1ps

module ppp_step (
   input  ppp_pkg::phase_type phase,
   input  logic               paren_closed,
   input  logic [7:0]         ch,
   output ppp_pkg::step_type  step
);
   import ppp_pkg::*;

   logic is_ident;
   logic is_digit;

   assign is_ident = ch inside {CH_UNDERSCORE, [CH_LOWER_A:CH_LOWER_Z], [CH_UPPER_A:CH_UPPER_Z]};
   assign is_digit = ch inside {[CH_ZERO:CH_NINE]};

   // A byte that matches nothing below sends the path to the error phase.
   always_comb begin
      step       = '0;
      step.phase = PH_ERROR;
      step.role  = ROLE_NONE;
      case (phase)
         PH_START: begin
            if (ch == CH_LPAREN) begin
               step.role  = ROLE_BRACKET;
               step.phase = PH_TYPE_FIRST;
            end else if (is_ident) begin
               step.role  = ROLE_PROP;
               step.phase = PH_NAME;
            end
         end
         PH_NAME: begin
            if (is_ident) begin
               step.role  = ROLE_PROP;
               step.phase = PH_NAME;
            end else if (ch == CH_LBRACKET) begin
               step.role      = ROLE_BRACKET;
               step.start_idx = 1'b1;
               step.phase     = PH_UIDX_FIRST;
            end else if (ch == CH_DOT) begin
               step.role      = ROLE_SEP;
               step.next_comp = 1'b1;
               step.phase     = PH_START;
            end
         end
         PH_UIDX_FIRST, PH_TIDX_FIRST: begin
            if (is_digit) begin
               step.role    = ROLE_DIGIT;
               step.add_dig = 1'b1;
               step.phase   = (phase == PH_UIDX_FIRST) ? PH_UIDX_DIG : PH_TIDX_DIG;
            end
         end
         PH_UIDX_DIG, PH_TIDX_DIG: begin
            if (is_digit) begin
               step.role    = ROLE_DIGIT;
               step.add_dig = 1'b1;
               step.phase   = phase;
            end else if (ch == CH_RBRACKET) begin
               step.role  = ROLE_BRACKET;
               step.done  = 1'b1;
               step.phase = (phase == PH_UIDX_DIG || paren_closed) ? PH_AFTER : PH_NEED_CLOSE;
            end
         end
         PH_AFTER, PH_CLOSED: begin
            if (ch == CH_DOT) begin
               step.role      = ROLE_SEP;
               step.next_comp = 1'b1;
               step.phase     = PH_START;
            end else if (phase == PH_CLOSED && ch == CH_LBRACKET) begin
               step.role      = ROLE_BRACKET;
               step.start_idx = 1'b1;
               step.phase     = PH_TIDX_FIRST;
            end
         end
         PH_TYPE_FIRST: begin
            if (is_ident) begin
               step.role  = ROLE_TYPE;
               step.phase = PH_TYPE;
            end
         end
         PH_TYPE: begin
            if (is_ident) begin
               step.role  = ROLE_TYPE;
               step.phase = PH_TYPE;
            end else if (ch == CH_DOT) begin
               step.role  = ROLE_SEP;
               step.phase = PH_PROP_FIRST;
            end
         end
         PH_PROP_FIRST: begin
            if (is_ident) begin
               step.role  = ROLE_PROP;
               step.phase = PH_PROP;
            end
         end
         PH_PROP: begin
            if (is_ident) begin
               step.role  = ROLE_PROP;
               step.phase = PH_PROP;
            end else if (ch == CH_RPAREN) begin
               step.role      = ROLE_BRACKET;
               step.set_paren = 1'b1;
               step.phase     = PH_CLOSED;
            end else if (ch == CH_LBRACKET) begin
               step.role      = ROLE_BRACKET;
               step.start_idx = 1'b1;
               step.phase     = PH_TIDX_FIRST;
            end
         end
         PH_NEED_CLOSE: begin
            if (ch == CH_RPAREN) begin
               step.role      = ROLE_BRACKET;
               step.set_paren = 1'b1;
               step.phase     = PH_AFTER;
            end
         end
         default: begin
            step.phase = PH_ERROR;
         end
      endcase
   end

endmodule

// ===== sv/property_path_parser_unit.sv =====
`timescale 1ns / 1ps

// Property path parser: checks a dotted property path one byte per word.
//
// Request channel (req_*): one path byte per word with a last flag, or a
// word with req_empty_req set that stands for a whole empty path. Response
// channel (rsp_*): exactly one word per request word, in order, giving the
// byte's role, the component number, the running index value, the index
// flags and, on the last byte, the final status of the path.
//
// A request word, once accepted, sits in the input register, where the byte
// decode works on it, and moves on into the response register as soon as
// that is free. Throughput is one word per cycle while the receiver does not
// stall; the parse state is updated at the same edge that loads the
// response, so consecutive bytes follow each other without a gap.
//
// When the receiver stalls, the response register holds its word and the
// input register may still take one more request word; only then does
// req_stall rise. Synchronous reset empties both registers and returns the
// parse state to the start of the first component of a fresh path.
module property_path_parser_unit #(
   parameter int INDEX_BITS = 32,
   parameter int COUNT_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_last,
   input  logic        req_empty_req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_role,
   output logic [7:0]  rsp_component_number,
   output logic [31:0] rsp_index_value,
   output logic        rsp_index_done,
   output logic        rsp_index_overflow,
   output logic        rsp_final_res,
   output logic [1:0]  rsp_status
);
   import ppp_pkg::*;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_ch_ff;
   logic       in_last_ff;
   logic       in_empty_ff;

   // Parse state.
   phase_type             phase_ff, phase_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [INDEX_BITS-1:0] acc_ff, acc_in;
   logic                  paren_ff, paren_in;
   logic                  ovf_ff, ovf_in;

   // Response register.
   logic        out_valid_ff, out_valid_in;
   logic [2:0]  out_role_ff;
   logic [7:0]  out_count_ff;
   logic [31:0] out_index_ff;
   logic        out_done_ff;
   logic        out_ovf_ff;
   logic        out_final_ff;
   logic [1:0]  out_status_ff;

   logic        req_take;
   logic        out_free;
   logic        load;
   step_type    step;

   // Working values of this byte, before the end-of-path reset.
   logic [COUNT_BITS-1:0] count_step;
   logic [INDEX_BITS-1:0] acc_step;
   logic                  ovf_step;
   logic                  paren_step;
   logic [INDEX_BITS+3:0] acc_times_ten;
   logic [3:0]            digit;
   logic                  acc_sat;
   logic [7:0]            count_shown;
   logic [31:0]           index_shown;
   logic [1:0]            status_word;

   // The response register frees up when it is empty or being read this cycle.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign load      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (load ? 1'b0 : in_valid_ff);
   assign out_valid_in = load ? 1'b1 : (out_free ? 1'b0 : out_valid_ff);

   ppp_step u_step (
      .phase        (phase_ff),
      .paren_closed (paren_ff),
      .ch           (in_ch_ff),
      .step         (step)
   );

   // Index accumulate: acc * 10 + digit in a widened word; anything in the
   // top four bits means the index no longer fits and it saturates.
   assign digit         = 4'(in_ch_ff - CH_ZERO);
   assign acc_times_ten = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                          + (INDEX_BITS+4)'(digit);
   assign acc_sat       = |acc_times_ten[INDEX_BITS+3:INDEX_BITS];

   always_comb begin
      count_step = count_ff;
      acc_step   = acc_ff;
      ovf_step   = ovf_ff;
      paren_step = paren_ff | step.set_paren;
      if (step.next_comp) begin
         // A separator opens the next component with a clean index.
         if (count_ff != '1) begin
            count_step = count_ff + 1'b1;
         end
         acc_step   = '0;
         ovf_step   = 1'b0;
         paren_step = 1'b0;
      end else if (step.start_idx) begin
         acc_step = '0;
         ovf_step = 1'b0;
      end else if (step.add_dig) begin
         if (acc_sat) begin
            acc_step = '1;
            ovf_step = 1'b1;
         end else begin
            acc_step = acc_times_ten[INDEX_BITS-1:0];
         end
      end
   end

   // The response fields are fixed in width; wider internal counts are
   // shown capped at the field's maximum.
   generate
      if (COUNT_BITS > 8) begin : g_count_cap
         assign count_shown = (|count_step[COUNT_BITS-1:8]) ? 8'hFF : count_step[7:0];
      end else begin : g_count_ext
         assign count_shown = 8'(count_step);
      end
      if (INDEX_BITS > 32) begin : g_index_cap
         assign index_shown = (|acc_step[INDEX_BITS-1:32]) ? 32'hFFFF_FFFF : acc_step[31:0];
      end else begin : g_index_ext
         assign index_shown = 32'(acc_step);
      end
   endgenerate

   // A path may end after an identifier, a closed index or a typed form's ')'.
   always_comb begin
      if (!in_last_ff) begin
         status_word = ST_PARSING;
      end else if (step.phase == PH_NAME || step.phase == PH_AFTER
                   || step.phase == PH_CLOSED) begin
         status_word = ST_COMPLETED;
      end else begin
         status_word = ST_ERROR;
      end
   end

   // Next parse state. An empty-path word or the last byte of a path puts
   // everything back to the start of a fresh path.
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      acc_in   = acc_ff;
      paren_in = paren_ff;
      ovf_in   = ovf_ff;
      if (load) begin
         if (in_empty_ff || in_last_ff) begin
            phase_in = PH_START;
            count_in = '0;
            acc_in   = '0;
            paren_in = 1'b0;
            ovf_in   = 1'b0;
         end else begin
            phase_in = step.phase;
            count_in = count_step;
            acc_in   = acc_step;
            paren_in = paren_step;
            ovf_in   = ovf_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_START;
         count_ff     <= '0;
         acc_ff       <= '0;
         paren_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         acc_ff       <= acc_in;
         paren_ff     <= paren_in;
         ovf_ff       <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ch_ff    <= req_ch;
         in_last_ff  <= req_last;
         in_empty_ff <= req_empty_req;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (in_empty_ff) begin
            out_role_ff   <= ROLE_NONE;
            out_count_ff  <= '0;
            out_index_ff  <= '0;
            out_done_ff   <= 1'b0;
            out_ovf_ff    <= 1'b0;
            out_final_ff  <= 1'b1;
            out_status_ff <= ST_NOT_FOUND;
         end else begin
            out_role_ff   <= step.role;
            out_count_ff  <= count_shown;
            out_index_ff  <= index_shown;
            out_done_ff   <= step.done;
            out_ovf_ff    <= ovf_step;
            out_final_ff  <= in_last_ff;
            out_status_ff <= status_word;
         end
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_role             = out_role_ff;
   assign rsp_component_number = out_count_ff;
   assign rsp_index_value      = out_index_ff;
   assign rsp_index_done       = out_done_ff;
   assign rsp_index_overflow   = out_ovf_ff;
   assign rsp_final_res        = out_final_ff;
   assign rsp_status           = out_status_ff;

`ifndef SYNTHESIS
   // Only the last byte of a path carries a final status.
   a_status_final : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_final_ff |-> out_status_ff == ST_PARSING)
      else $error("status reported on a byte that is not last");

   a_final_status : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_final_ff |-> out_status_ff != ST_PARSING)
      else $error("last byte without a final status");

   // A closed index is always reported on a bracket.
   a_done_bracket : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_done_ff |-> out_role_ff == ROLE_BRACKET)
      else $error("index closed on a byte that is not a bracket");

   // After the end of a path the parse state is back at its start.
   a_path_reset : assert property (@(posedge clock) disable iff (reset)
      load && (in_last_ff || in_empty_ff) |=>
         phase_ff == PH_START && count_ff == '0 && acc_ff == '0 && !ovf_ff)
      else $error("parse state not cleared at the end of a path");

   // The empty-path answer carries no component information.
   a_not_found : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_status_ff == ST_NOT_FOUND |->
         out_role_ff == ROLE_NONE && out_count_ff == 8'd0 && out_final_ff)
      else $error("malformed empty-path response");
`endif

endmodule

// ===== tb/sv/tb_property_path_parser_unit.sv =====
`timescale 1ns / 1ps

// Testbench for the property path parser. Path bytes go in as request words.
// A model of the parse state runs alongside the block and works out the
// response word that each accepted request word should cause. Responses are
// compared field by field, in order. Both sides idle at random, apart from
// one stretch in the middle of the random part where they do not.
module tb_property_path_parser_unit;

   import ppp_pkg::*;

   // One response word as the block reports it.
   typedef struct packed {
      logic [2:0]  role;
      logic [7:0]  comp_no;
      logic [31:0] idx;
      logic        idx_done;
      logic        idx_ovf;
      logic        fin;
      logic [1:0]  status;
   } byte_report_type;

   // One row of the directed table. Where "literal" is set, the response is
   // typed in the row itself; every other row is checked against the model.
   typedef struct packed {
      logic [7:0]      ch;
      logic            last;
      logic            empty;
      logic            literal;
      byte_report_type want;
   } stim_row_type;

   localparam byte_report_type NO_LIT = '0;
   localparam int N_DIRECTED = 26;
   localparam int RANDOM_WORDS = 1700;

   // The directed part: an empty path with a stray byte and last flag that
   // must both be ignored, a rejected byte followed by a byte that would be
   // valid but comes after the error, a typed form with its index inside the
   // closing parenthesis, and a plain name whose index saturates before a
   // separator opens a second component.
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{8'hA5, 1'b1, 1'b1, 1'b1,
        '{ROLE_NONE, 8'd0, 32'd0, 1'b0, 1'b0, 1'b1, ST_NOT_FOUND}},
      '{8'hFF, 1'b0, 1'b0, 1'b1,
        '{ROLE_NONE, 8'd0, 32'd0, 1'b0, 1'b0, 1'b0, ST_PARSING}},
      '{"a", 1'b1, 1'b0, 1'b1,
        '{ROLE_NONE, 8'd0, 32'd0, 1'b0, 1'b0, 1'b1, ST_ERROR}},
      '{CH_LPAREN,   1'b0, 1'b0, 1'b0, NO_LIT},
      '{"z",         1'b0, 1'b0, 1'b0, NO_LIT},
      '{CH_DOT,      1'b0, 1'b0, 1'b0, NO_LIT},
      '{"A",         1'b0, 1'b0, 1'b0, NO_LIT},
      '{CH_LBRACKET, 1'b0, 1'b0, 1'b0, NO_LIT},
      '{"7",         1'b0, 1'b0, 1'b0, NO_LIT},
      '{CH_RBRACKET, 1'b0, 1'b0, 1'b0, NO_LIT},
      '{CH_RPAREN,   1'b1, 1'b0, 1'b0, NO_LIT},
      '{"Z",         1'b0, 1'b0, 1'b0, NO_LIT},
      '{CH_LBRACKET, 1'b0, 1'b0, 1'b0, NO_LIT},
      '{"4",         1'b0, 1'b0, 1'b0, NO_LIT},
      '{"2",         1'b0, 1'b0, 1'b0, NO_LIT},
      '{"9",         1'b0, 1'b0, 1'b0, NO_LIT},
      '{"4",         1'b0, 1'b0, 1'b0, NO_LIT},
      '{"9",         1'b0, 1'b0, 1'b0, NO_LIT},
      '{"6",         1'b0, 1'b0, 1'b0, NO_LIT},
      '{"7",         1'b0, 1'b0, 1'b0, NO_LIT},
      '{"2",         1'b0, 1'b0, 1'b0, NO_LIT},
      '{"9",         1'b0, 1'b0, 1'b0, NO_LIT},
      '{"6",         1'b0, 1'b0, 1'b0, NO_LIT},
      '{CH_RBRACKET, 1'b0, 1'b0, 1'b0, NO_LIT},
      '{CH_DOT,      1'b0, 1'b0, 1'b0, NO_LIT},
      '{"q",         1'b1, 1'b0, 1'b0, NO_LIT}
   };

   // Clock, reset and the block's ports. Every input starts at a known value.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_ch = 8'd0;
   logic        req_last = 1'b0;
   logic        req_empty_req = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_role;
   logic [7:0]  rsp_component_number;
   logic [31:0] rsp_index_value;
   logic        rsp_index_done;
   logic        rsp_index_overflow;
   logic        rsp_final_res;
   logic [1:0]  rsp_status;

   // Parse state of the model, starting from its reset values.
   phase_type   path_phase = PH_START;
   logic [7:0]  comp_count = 8'd0;
   logic [31:0] idx_acc = 32'd0;
   logic        paren_seen = 1'b0;
   logic        idx_sat = 1'b0;

   // Responses still owed by the block, oldest first.
   byte_report_type pending_reports [$];
   logic [7:0]      path_q [$];

   // When set, neither side idles.
   logic calm = 1'b0;

   int words_sent = 0;
   int words_checked = 0;
   int mismatches = 0;
   int paths_completed = 0;
   int paths_failed = 0;
   int paths_empty = 0;
   int sat_words = 0;
   int top_component = 0;

   always #1 clock = ~clock;

   property_path_parser_unit u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_ch               (req_ch),
      .req_last             (req_last),
      .req_empty_req        (req_empty_req),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_role             (rsp_role),
      .rsp_component_number (rsp_component_number),
      .rsp_index_value      (rsp_index_value),
      .rsp_index_done       (rsp_index_done),
      .rsp_index_overflow   (rsp_index_overflow),
      .rsp_final_res        (rsp_final_res),
      .rsp_status           (rsp_status)
   );

   function automatic logic is_name_char(input logic [7:0] ch);
      return ch == CH_UNDERSCORE || (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) ||
             (ch >= CH_UPPER_A && ch <= CH_UPPER_Z);
   endfunction

   // Returns the parse state to the start of a fresh path.
   function automatic void clear_path();
      path_phase = PH_START;
      comp_count = 8'd0;
      idx_acc = 32'd0;
      paren_seen = 1'b0;
      idx_sat = 1'b0;
   endfunction

   // Advances the parse state by one request word and returns the response
   // word that the block should give for it.
   function automatic byte_report_type parse_step(input logic [7:0] ch, input logic last,
                                                  input logic empty);
      byte_report_type rep;
      phase_type       nxt;
      logic            name_ch;
      logic            digit_ch;
      logic            begin_idx;
      logic            new_comp;
      logic            take_digit;
      longint unsigned digit_val;
      rep = '0;
      nxt = path_phase;
      name_ch = is_name_char(ch);
      digit_ch = ch >= CH_ZERO && ch <= CH_NINE;
      begin_idx = 1'b0;
      new_comp = 1'b0;
      take_digit = 1'b0;
      // An empty path abandons whatever was under way.
      if (empty) begin
         clear_path();
         rep.fin = 1'b1;
         rep.status = ST_NOT_FOUND;
         return rep;
      end
      case (path_phase)
         PH_START: begin
            if (ch == CH_LPAREN) begin
               rep.role = ROLE_BRACKET;
               nxt = PH_TYPE_FIRST;
            end else if (name_ch) begin
               rep.role = ROLE_PROP;
               nxt = PH_NAME;
            end else nxt = PH_ERROR;
         end
         PH_NAME: begin
            if (name_ch) rep.role = ROLE_PROP;
            else if (ch == CH_LBRACKET) begin
               rep.role = ROLE_BRACKET;
               begin_idx = 1'b1;
               nxt = PH_UIDX_FIRST;
            end else if (ch == CH_DOT) begin
               rep.role = ROLE_SEP;
               new_comp = 1'b1;
               nxt = PH_START;
            end else nxt = PH_ERROR;
         end
         PH_UIDX_FIRST, PH_TIDX_FIRST: begin
            if (digit_ch) begin
               rep.role = ROLE_DIGIT;
               take_digit = 1'b1;
               nxt = (path_phase == PH_UIDX_FIRST) ? PH_UIDX_DIG : PH_TIDX_DIG;
            end else nxt = PH_ERROR;
         end
         PH_UIDX_DIG, PH_TIDX_DIG: begin
            if (digit_ch) begin
               rep.role = ROLE_DIGIT;
               take_digit = 1'b1;
            end else if (ch == CH_RBRACKET) begin
               rep.role = ROLE_BRACKET;
               rep.idx_done = 1'b1;
               // An index inside the typed form still owes its ')'.
               nxt = (path_phase == PH_UIDX_DIG || paren_seen) ? PH_AFTER : PH_NEED_CLOSE;
            end else nxt = PH_ERROR;
         end
         PH_AFTER, PH_CLOSED: begin
            if (ch == CH_DOT) begin
               rep.role = ROLE_SEP;
               new_comp = 1'b1;
               nxt = PH_START;
            end else if (path_phase == PH_CLOSED && ch == CH_LBRACKET) begin
               rep.role = ROLE_BRACKET;
               begin_idx = 1'b1;
               nxt = PH_TIDX_FIRST;
            end else nxt = PH_ERROR;
         end
         PH_TYPE_FIRST: begin
            if (name_ch) begin
               rep.role = ROLE_TYPE;
               nxt = PH_TYPE;
            end else nxt = PH_ERROR;
         end
         PH_TYPE: begin
            if (name_ch) rep.role = ROLE_TYPE;
            else if (ch == CH_DOT) begin
               rep.role = ROLE_SEP;
               nxt = PH_PROP_FIRST;
            end else nxt = PH_ERROR;
         end
         PH_PROP_FIRST: begin
            if (name_ch) begin
               rep.role = ROLE_PROP;
               nxt = PH_PROP;
            end else nxt = PH_ERROR;
         end
         PH_PROP: begin
            if (name_ch) rep.role = ROLE_PROP;
            else if (ch == CH_RPAREN) begin
               rep.role = ROLE_BRACKET;
               paren_seen = 1'b1;
               nxt = PH_CLOSED;
            end else if (ch == CH_LBRACKET) begin
               rep.role = ROLE_BRACKET;
               begin_idx = 1'b1;
               nxt = PH_TIDX_FIRST;
            end else nxt = PH_ERROR;
         end
         PH_NEED_CLOSE: begin
            if (ch == CH_RPAREN) begin
               rep.role = ROLE_BRACKET;
               paren_seen = 1'b1;
               nxt = PH_AFTER;
            end else nxt = PH_ERROR;
         end
         default: nxt = PH_ERROR;
      endcase
      if (begin_idx) begin
         idx_acc = 32'd0;
         idx_sat = 1'b0;
      end
      if (new_comp) begin
         if (comp_count != 8'hFF) comp_count = comp_count + 8'd1;
         idx_acc = 32'd0;
         idx_sat = 1'b0;
         paren_seen = 1'b0;
      end
      // The index sticks at its maximum once another digit would not fit.
      if (take_digit) begin
         digit_val = 64'(ch - CH_ZERO);
         if (64'(idx_acc) > (64'h0000_0000_FFFF_FFFF - digit_val) / 64'd10) begin
            idx_acc = 32'hFFFF_FFFF;
            idx_sat = 1'b1;
         end else idx_acc = 32'(64'(idx_acc) * 64'd10 + digit_val);
      end
      path_phase = nxt;
      rep.comp_no = comp_count;
      rep.idx = idx_acc;
      rep.idx_ovf = idx_sat;
      rep.fin = last;
      if (last) begin
         rep.status = (nxt == PH_NAME || nxt == PH_AFTER || nxt == PH_CLOSED) ?
                      ST_COMPLETED : ST_ERROR;
         clear_path();
      end
      return rep;
   endfunction

   // Offers one request word, waits until the block takes it, and only then
   // records the response that it owes. Outside the calm stretch the request
   // side may pause at random before the word.
   task automatic send_word(input logic [7:0] ch, input logic last, input logic empty,
                            input logic literal, input byte_report_type want);
      byte_report_type rep;
      if (!calm && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch <= ch;
      req_last <= last;
      req_empty_req <= empty;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      rep = parse_step(ch, last, empty);
      pending_reports.push_back(literal ? want : rep);
      words_sent++;
   endtask

   // Sends the path held in path_q. An abandoned path stops part of the way
   // and is cut short by an empty-path word.
   task automatic send_path(input logic abandon);
      int stop;
      stop = abandon ? $urandom_range(0, path_q.size() - 1) : path_q.size();
      for (int i = 0; i < stop; i++)
         send_word(path_q[i], i == path_q.size() - 1, 1'b0, 1'b0, NO_LIT);
      if (abandon)
         send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, 1'b0, NO_LIT);
   endtask

   function automatic logic [7:0] rand_name_char();
      int k;
      k = $urandom_range(0, 52);
      if (k == 52) return CH_UNDERSCORE;
      else if (k < 26) return 8'(CH_LOWER_A + k);
      else return 8'(CH_UPPER_A + k - 26);
   endfunction

   task automatic push_name();
      repeat ($urandom_range(1, 6)) path_q.push_back(rand_name_char());
   endtask

   // A bracketed index. Mostly short, sometimes right at the edge of the
   // 32-bit range, sometimes ten to fourteen digits so that it mostly saturates.
   task automatic push_index();
      string num;
      int    pick;
      pick = $urandom_range(0, 99);
      path_q.push_back(CH_LBRACKET);
      if (pick < 8) begin
         num = $sformatf("%0d", 64'd4294967290 + 64'($urandom_range(0, 9)));
         for (int i = 0; i < num.len(); i++) path_q.push_back(num[i]);
      end else begin
         repeat ((pick < 16) ? $urandom_range(10, 14) : $urandom_range(1, 3))
            path_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      end
      path_q.push_back(CH_RBRACKET);
   endtask

   // Builds a well-formed path of one to four components, then breaks a
   // share of them: a byte replaced, the tail cut off, a stray byte put in,
   // or the whole path swapped for noise.
   task automatic build_path();
      int kind;
      path_q.delete();
      repeat ($urandom_range(1, 4)) begin
         if (path_q.size() != 0) path_q.push_back(CH_DOT);
         if ($urandom_range(0, 99) < 60) begin
            push_name();
            if ($urandom_range(0, 99) < 40) push_index();
         end else begin
            path_q.push_back(CH_LPAREN);
            push_name();
            path_q.push_back(CH_DOT);
            push_name();
            case ($urandom_range(0, 2))
               0: path_q.push_back(CH_RPAREN);
               1: begin
                  path_q.push_back(CH_RPAREN);
                  push_index();
               end
               default: begin
                  push_index();
                  path_q.push_back(CH_RPAREN);
               end
            endcase
         end
      end
      kind = $urandom_range(0, 99);
      if (kind < 6)
         path_q[$urandom_range(0, path_q.size() - 1)] = 8'($urandom_range(0, 255));
      else if (kind < 10 && path_q.size() > 1)
         void'(path_q.pop_back());
      else if (kind < 14)
         path_q.insert($urandom_range(0, path_q.size()), 8'($urandom_range(0, 255)));
      else if (kind < 18) begin
         path_q.delete();
         repeat ($urandom_range(1, 6)) path_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want_v,
                              input logic [63:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0h, got %0h", name, want_v, got_v);
         mismatches++;
      end
   endtask

   // The response side stalls at random, except in the calm stretch.
   always @(posedge clock) begin
      rsp_stall <= !calm && $urandom_range(0, 99) < 10;
   end

   // Every response word taken is compared with the oldest one owed.
   always @(posedge clock) begin
      byte_report_type exp_rep;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $error("response word with none expected");
            mismatches++;
         end else begin
            exp_rep = pending_reports.pop_front();
            check_field("role", exp_rep.role, rsp_role);
            check_field("component_number", exp_rep.comp_no, rsp_component_number);
            check_field("index_value", exp_rep.idx, rsp_index_value);
            check_field("index_done", exp_rep.idx_done, rsp_index_done);
            check_field("index_overflow", exp_rep.idx_ovf, rsp_index_overflow);
            check_field("final_res", exp_rep.fin, rsp_final_res);
            check_field("status", exp_rep.status, rsp_status);
            words_checked++;
            if (exp_rep.status == ST_COMPLETED) paths_completed++;
            if (exp_rep.status == ST_ERROR) paths_failed++;
            if (exp_rep.status == ST_NOT_FOUND) paths_empty++;
            if (exp_rep.idx_ovf) sat_words++;
            if (exp_rep.comp_no > top_component) top_component = exp_rep.comp_no;
         end
      end
   end

   initial begin
      int random_start;
      int guard;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++)
         send_word(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].empty,
                   directed_rows[i].literal, directed_rows[i].want);

      random_start = words_sent;

      // One long path whose component number runs into its cap.
      path_q.delete();
      for (int i = 0; i < 260; i++) begin
         if (i != 0) path_q.push_back(CH_DOT);
         path_q.push_back(rand_name_char());
      end
      send_path(1'b0);

      while (words_sent - random_start < RANDOM_WORDS) begin
         calm = (words_sent - random_start >= 800) && (words_sent - random_start < 1100);
         if ($urandom_range(0, 99) < 3)
            send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1,
                      1'b0, NO_LIT);
         else begin
            build_path();
            send_path($urandom_range(0, 99) < 3);
         end
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // Drain the responses still owed, then keep the clock running so that a
      // stray extra word would show up.
      guard = 0;
      while (pending_reports.size() != 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      if (pending_reports.size() != 0) begin
         $display("Responses still owed at the end: %0d", pending_reports.size());
         $display("== FAIL ==");
         $finish;
      end else begin
         repeat (8) @(posedge clock);
         $display("Sent %0d request words; checked %0d responses, %0d mismatches.",
                  words_sent, words_checked, mismatches);
         $display("Paths: %0d completed, %0d in error, %0d empty; top component %0d, %0d saturated.",
                  paths_completed, paths_failed, paths_empty, top_component, sat_words);
         if (mismatches == 0) begin
            $display("== PASS ==");
         end else begin
            $display("== FAIL ==");
         end
         $finish;
      end
   end

   // Backstop in case the block stops answering altogether.
   initial begin
      #2_000_000;
      $display("Run timed out.");
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
sv/ppp_pkg.sv
sv/ppp_step.sv
sv/property_path_parser_unit.sv
tb/sv/tb_property_path_parser_unit.sv
